FILE: sv/optical_gesture_classifier_defines.svh
// assertion macros shared by the gesture classifier
`ifndef OPTICAL_GESTURE_CLASSIFIER_DEFINES_SVH
`define OPTICAL_GESTURE_CLASSIFIER_DEFINES_SVH

// same-cycle implication, checked on clk with reset masked
`define OGC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gesture classifier check failed");

// next-cycle implication, checked on clk with reset masked
`define OGC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gesture classifier check failed");

`endif

FILE: sv/ogc_pkg.sv
// shared constants and types of the gesture classifier
`default_nettype none

package ogc_pkg;

    localparam int OGC_MAX_SETS = 32;
    localparam int CNT_W        = $clog2(OGC_MAX_SETS + 1);
    localparam int IDX_W        = $clog2(OGC_MAX_SETS);
    localparam int SAMPLE_W     = 32;

    // input commands
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_CLOSE  = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_EDGE  = 2'd0;
    localparam logic [1:0] CFG_SWIPE = 2'd1;
    localparam logic [1:0] CFG_STILL = 2'd2;

    localparam logic [7:0] EDGE_RST  = 8'd10;
    localparam logic [8:0] SWIPE_RST = 9'd50;
    localparam logic [8:0] STILL_RST = 9'd20;

    // gesture codes
    localparam logic [2:0] G_NONE  = 3'd0;
    localparam logic [2:0] G_UP    = 3'd1;
    localparam logic [2:0] G_DOWN  = 3'd2;
    localparam logic [2:0] G_LEFT  = 3'd3;
    localparam logic [2:0] G_RIGHT = 3'd4;
    localparam logic [2:0] G_NEAR  = 3'd5;
    localparam logic [2:0] G_FAR   = 3'd6;

    // axis direction codes, two's complement -1/0/+1
    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_POS  = 2'b01;
    localparam logic [1:0] DIR_NEG  = 2'b11;

    localparam logic [CNT_W-1:0] MIN_BATCH = CNT_W'(4);
    localparam logic [7:0] STILL_LIMIT = 8'd10;
    localparam logic [7:0] DRIFT_LIMIT = 8'd2;
    localparam logic [14:0] RATIO_SCALE = 15'd100;

    localparam int DIV_STEPS = 15;
    localparam int DIV_CNT_W = 4;

    typedef struct packed {
        logic accept;
        logic check_first;
        logic check_last;
        logic div_start;
        logic update;
        logic close_done;
    } ogc_cmd_t;

    typedef struct packed {
        logic long_batch;
        logic hit;
        logic at_end;
        logic div_busy;
        logic div_wrapped;
    } ogc_status_t;

endpackage

`default_nettype wire

FILE: sv/ogc_ram.sv
// generic single-write, registered-read memory
`default_nettype none

module ogc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/ogc_ctrl.sv
// sequencer of the batch close: scans, divisions, update and decode
`default_nettype none

module ogc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    input  wire logic [1:0]         cmd,
    input  wire logic               result_busy,
    input  wire ogc_pkg::ogc_status_t st,
    output logic                    sample_stall,
    output ogc_pkg::ogc_cmd_t       ctl
);
    import ogc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BEGIN = 4'd1;
    localparam logic [3:0] S_FRD   = 4'd2;
    localparam logic [3:0] S_FCHK  = 4'd3;
    localparam logic [3:0] S_LRD   = 4'd4;
    localparam logic [3:0] S_LCHK  = 4'd5;
    localparam logic [3:0] S_DIVS  = 4'd6;
    localparam logic [3:0] S_DIVW  = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;
    localparam logic [3:0] S_DEC   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    // input beats only while idle; a finish waits for the result slot
    assign sample_stall = (state_reg != S_IDLE) || (result_busy && cmd == CMD_FINISH);
    assign accept       = sample_valid && !sample_stall;

    // commands to the datapath
    always_comb
    begin
        ctl             = '0;
        ctl.accept      = accept;
        ctl.check_first = (state_reg == S_FCHK);
        ctl.check_last  = (state_reg == S_LCHK);
        ctl.div_start   = (state_reg == S_DIVS);
        ctl.update      = (state_reg == S_UPD);
        ctl.close_done  = (state_reg == S_DEC);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept && cmd == CMD_CLOSE) state_next = S_BEGIN;
            S_BEGIN: state_next = st.long_batch ? S_FRD : S_DEC;
            S_FRD:   state_next = S_FCHK;
            S_FCHK:
            begin
                if (st.hit)
                    state_next = S_LRD;
                else if (st.at_end)
                    state_next = S_DEC;
                else
                    state_next = S_FRD;
            end
            S_LRD:   state_next = S_LCHK;
            S_LCHK:  state_next = st.hit ? S_DIVS : S_LRD;
            S_DIVS:  state_next = S_DIVW;
            S_DIVW:
            begin
                if (!st.div_busy)
                    state_next = st.div_wrapped ? S_UPD : S_DIVS;
            end
            S_UPD:   state_next = S_DEC;
            S_DEC:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

FILE: sv/ogc_datapath.sv
// sample store, divider, accumulators, event counters and decode
`default_nettype none

module ogc_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ogc_pkg::ogc_cmd_t  ctl,
    output ogc_pkg::ogc_status_t    st,
    input  wire logic [1:0]         cmd,
    input  wire logic [7:0]         up_level,
    input  wire logic [7:0]         down_level,
    input  wire logic [7:0]         left_level,
    input  wire logic [7:0]         right_level,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [8:0]         cfg_data,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [2:0]              gesture_code,
    output logic signed [15:0]      vertical_total,
    output logic signed [15:0]      horizontal_total
);
    import ogc_pkg::*;

    // configuration
    logic [7:0] edge_reg;
    logic [8:0] swipe_reg;
    logic [8:0] still_reg;

    // batch bookkeeping
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [SAMPLE_W-1:0] first_reg, first_next;
    logic [SAMPLE_W-1:0] last_reg, last_next;
    logic [SAMPLE_W-1:0] rdata;
    logic                ram_we;

    // divider
    logic [14:0]          quo_reg, quo_next;
    logic [9:0]           rem_reg, rem_next;
    logic [8:0]           den_reg, den_next;
    logic                 neg_reg, neg_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic                 busy_reg, busy_next;
    logic [1:0]           sel_reg, sel_next;
    logic signed [7:0]    ratio_reg [4];
    logic signed [7:0]    ratio_next [4];

    // gesture state
    logic signed [15:0] vacc_reg, vacc_next;
    logic signed [15:0] hacc_reg, hacc_next;
    logic [1:0]         vdir_reg, vdir_next;
    logic [1:0]         hdir_reg, hdir_next;
    logic [7:0]         still_ev_reg, still_ev_next;
    logic [7:0]         drift_ev_reg, drift_ev_next;
    logic [2:0]         verdict_reg, verdict_next;
    logic [2:0]         motion_reg, motion_next;

    // result slot
    logic               rvalid_reg, rvalid_next;
    logic [2:0]         rcode_reg, rcode_next;
    logic signed [15:0] rvert_reg, rvert_next;
    logic signed [15:0] rhorz_reg, rhorz_next;

    // combinational helpers
    logic [7:0]         div_a, div_b, div_mag;
    logic [14:0]        div_num;
    logic [9:0]         rem_sh;
    logic               div_ge;
    logic [7:0]         q_final;
    logic signed [8:0]  dv, dh;
    logic [8:0]         dv_mag, dh_mag;
    logic signed [16:0] vsum, hsum;
    logic signed [15:0] vsat, hsat;
    logic [1:0]         nvdir, nhdir;
    logic               small_d, zero_d, no_dir;
    logic [7:0]         se_bump, de_bump;
    logic [2:0]         dec_motion;

    function automatic logic above_all(input logic [SAMPLE_W-1:0] e, input logic [7:0] thr);
        above_all = (e[7:0] > thr) && (e[15:8] > thr) && (e[23:16] > thr) && (e[31:24] > thr);
    endfunction

    function automatic logic [7:0] bump8(input logic [7:0] c);
        bump8 = (c == 8'hFF) ? c : c + 8'd1;
    endfunction

    function automatic logic [16:0] abs16(input logic signed [15:0] v);
        logic signed [16:0] w;
        w = {v[15], v};
        abs16 = w[16] ? 17'(-w) : 17'(w);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        if (v[16] != v[15])
            sat16 = v[16] ? 16'sh8000 : 16'sh7FFF;
        else
            sat16 = v[15:0];
    endfunction

    function automatic logic [1:0] axis_dir(input logic signed [15:0] acc, input logic [8:0] s);
        logic signed [16:0] a;
        logic signed [16:0] ps;
        a  = {acc[15], acc};
        ps = $signed({8'd0, s});
        if (a >= ps)
            axis_dir = DIR_POS;
        else if (a <= -ps)
            axis_dir = DIR_NEG;
        else
            axis_dir = DIR_NONE;
    endfunction

    function automatic logic [2:0] decode_motion(
        input logic [2:0] verdict, input logic [1:0] vd, input logic [1:0] hd,
        input logic signed [15:0] va, input logic signed [15:0] ha, input logic [2:0] cur);
        logic vbig;
        vbig = abs16(va) > abs16(ha);
        decode_motion = cur;
        if (verdict == G_NEAR || verdict == G_FAR)
            decode_motion = verdict;
        else if (vd == DIR_NEG && hd == DIR_NONE)
            decode_motion = G_UP;
        else if (vd == DIR_POS && hd == DIR_NONE)
            decode_motion = G_DOWN;
        else if (vd == DIR_NONE && hd == DIR_POS)
            decode_motion = G_RIGHT;
        else if (vd == DIR_NONE && hd == DIR_NEG)
            decode_motion = G_LEFT;
        else if (vd == DIR_NEG && hd == DIR_POS)
            decode_motion = vbig ? G_UP : G_RIGHT;
        else if (vd == DIR_POS && hd == DIR_NEG)
            decode_motion = vbig ? G_DOWN : G_LEFT;
        else if (vd == DIR_NEG && hd == DIR_NEG)
            decode_motion = vbig ? G_UP : G_LEFT;
        else if (vd == DIR_POS && hd == DIR_POS)
            decode_motion = vbig ? G_DOWN : G_RIGHT;
    endfunction

    // sample store
    assign ram_we = ctl.accept && (cmd == CMD_PUSH || cmd == CMD_CLOSE)
                    && (count_reg < CNT_W'(OGC_MAX_SETS));

    ogc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (OGC_MAX_SETS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({right_level, left_level, down_level, up_level}),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // status to the controller
    always_comb
    begin
        st             = '0;
        st.long_batch  = count_reg > MIN_BATCH;
        st.hit         = above_all(rdata, edge_reg);
        st.at_end      = (idx_reg == IDX_W'(count_reg - CNT_W'(1)));
        st.div_busy    = busy_reg;
        st.div_wrapped = (sel_reg == 2'd0);
    end

    // divider operands: last/first sample, vertical then horizontal pair
    always_comb
    begin
        if (sel_reg[1])
        begin
            div_a = sel_reg[0] ? first_reg[23:16] : last_reg[23:16];
            div_b = sel_reg[0] ? first_reg[31:24] : last_reg[31:24];
        end
        else
        begin
            div_a = sel_reg[0] ? first_reg[7:0] : last_reg[7:0];
            div_b = sel_reg[0] ? first_reg[15:8] : last_reg[15:8];
        end
        div_mag = (div_a >= div_b) ? div_a - div_b : div_b - div_a;
        div_num = 15'({7'd0, div_mag} * RATIO_SCALE);
        rem_sh  = {rem_reg[8:0], quo_reg[14]};
        div_ge  = rem_sh >= {1'b0, den_reg};
        q_final = {quo_reg[6:0], div_ge};
    end

    // per-batch deltas and saturated sums
    always_comb
    begin
        dv     = {ratio_reg[0][7], ratio_reg[0]} - {ratio_reg[1][7], ratio_reg[1]};
        dh     = {ratio_reg[2][7], ratio_reg[2]} - {ratio_reg[3][7], ratio_reg[3]};
        dv_mag = dv[8] ? 9'(-dv) : 9'(dv);
        dh_mag = dh[8] ? 9'(-dh) : 9'(dh);
        vsum   = {vacc_reg[15], vacc_reg} + {{8{dv[8]}}, dv};
        hsum   = {hacc_reg[15], hacc_reg} + {{8{dh[8]}}, dh};
        vsat   = sat16(vsum);
        hsat   = sat16(hsum);
        nvdir  = axis_dir(vsat, swipe_reg);
        nhdir  = axis_dir(hsat, swipe_reg);
        small_d = (dv_mag < still_reg) && (dh_mag < still_reg);
        zero_d  = (dv == 9'sd0) && (dh == 9'sd0);
        no_dir  = (nvdir == DIR_NONE) && (nhdir == DIR_NONE);
        se_bump = bump8(still_ev_reg);
        de_bump = bump8(drift_ev_reg);
        dec_motion = decode_motion(verdict_reg, vdir_reg, hdir_reg, vacc_reg, hacc_reg,
                                   motion_reg);
    end

    // next-state logic
    always_comb
    begin
        count_next    = count_reg;
        idx_next      = idx_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        neg_next      = neg_reg;
        dcnt_next     = dcnt_reg;
        busy_next     = busy_reg;
        sel_next      = sel_reg;
        ratio_next    = ratio_reg;
        vacc_next     = vacc_reg;
        hacc_next     = hacc_reg;
        vdir_next     = vdir_reg;
        hdir_next     = hdir_reg;
        still_ev_next = still_ev_reg;
        drift_ev_next = drift_ev_reg;
        verdict_next  = verdict_reg;
        motion_next   = motion_reg;
        rvalid_next   = rvalid_reg && result_stall;
        rcode_next    = rcode_reg;
        rvert_next    = rvert_reg;
        rhorz_next    = rhorz_reg;

        // input beat: push, close or finish
        if (ctl.accept)
        begin
            if (ram_we)
                count_next = count_reg + CNT_W'(1);
            if (cmd == CMD_CLOSE)
                idx_next = '0;
            if (cmd == CMD_FINISH)
            begin
                rvalid_next   = 1'b1;
                rcode_next    = dec_motion;
                rvert_next    = vacc_reg;
                rhorz_next    = hacc_reg;
                count_next    = '0;
                vacc_next     = '0;
                hacc_next     = '0;
                vdir_next     = DIR_NONE;
                hdir_next     = DIR_NONE;
                still_ev_next = '0;
                drift_ev_next = '0;
                verdict_next  = G_NONE;
                motion_next   = G_NONE;
            end
        end

        // forward scan for the first valid sample
        if (ctl.check_first)
        begin
            if (st.hit)
            begin
                first_next = rdata;
                idx_next   = IDX_W'(count_reg - CNT_W'(1));
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end

        // backward scan for the last valid sample
        if (ctl.check_last)
        begin
            if (st.hit)
                last_next = rdata;
            else
                idx_next = idx_reg - IDX_W'(1);
        end

        // restoring divider, one quotient bit a cycle
        if (ctl.div_start)
        begin
            quo_next  = div_num;
            rem_next  = '0;
            den_next  = {1'b0, div_a} + {1'b0, div_b};
            neg_next  = div_a < div_b;
            dcnt_next = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = div_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
            quo_next  = {quo_reg[13:0], div_ge};
            dcnt_next = dcnt_reg - DIV_CNT_W'(1);
            if (dcnt_reg == DIV_CNT_W'(1))
            begin
                busy_next           = 1'b0;
                ratio_next[sel_reg] = neg_reg ? 8'(-q_final) : q_final;
                sel_next            = sel_reg + 2'd1;
            end
        end

        // accumulate, set directions and count still/drift events
        if (ctl.update)
        begin
            vacc_next = vsat;
            hacc_next = hsat;
            vdir_next = nvdir;
            hdir_next = nhdir;
            if (no_dir && small_d)
            begin
                if (zero_d)
                    still_ev_next = se_bump;
                else
                    drift_ev_next = de_bump;
                if (still_ev_next >= STILL_LIMIT && drift_ev_next >= DRIFT_LIMIT)
                    verdict_next = zero_d ? G_NEAR : G_FAR;
            end
            else if (!no_dir && small_d && zero_d)
            begin
                still_ev_next = se_bump;
                if (se_bump >= STILL_LIMIT)
                begin
                    vdir_next = DIR_NONE;
                    hdir_next = DIR_NONE;
                    vacc_next = '0;
                    hacc_next = '0;
                end
            end
        end

        // end of close: decode and start a new batch
        if (ctl.close_done)
        begin
            motion_next = dec_motion;
            count_next  = '0;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg     <= EDGE_RST;
            swipe_reg    <= SWIPE_RST;
            still_reg    <= STILL_RST;
            count_reg    <= '0;
            busy_reg     <= 1'b0;
            sel_reg      <= '0;
            vacc_reg     <= '0;
            hacc_reg     <= '0;
            vdir_reg     <= DIR_NONE;
            hdir_reg     <= DIR_NONE;
            still_ev_reg <= '0;
            drift_ev_reg <= '0;
            verdict_reg  <= G_NONE;
            motion_reg   <= G_NONE;
            rvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_EDGE:  edge_reg  <= cfg_data[7:0];
                    CFG_SWIPE: swipe_reg <= cfg_data;
                    CFG_STILL: still_reg <= cfg_data;
                    default:   ;
                endcase
            end
            count_reg    <= count_next;
            busy_reg     <= busy_next;
            sel_reg      <= sel_next;
            vacc_reg     <= vacc_next;
            hacc_reg     <= hacc_next;
            vdir_reg     <= vdir_next;
            hdir_reg     <= hdir_next;
            still_ev_reg <= still_ev_next;
            drift_ev_reg <= drift_ev_next;
            verdict_reg  <= verdict_next;
            motion_reg   <= motion_next;
            rvalid_reg   <= rvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
        dcnt_reg  <= dcnt_next;
        ratio_reg <= ratio_next;
        rcode_reg <= rcode_next;
        rvert_reg <= rvert_next;
        rhorz_reg <= rhorz_next;
    end

    assign result_valid     = rvalid_reg;
    assign gesture_code     = rcode_reg;
    assign vertical_total   = rvert_reg;
    assign horizontal_total = rhorz_reg;

endmodule

`default_nettype wire

FILE: sv/optical_gesture_classifier.sv
// Four-photodiode swipe gesture classifier. A finish beat waits while the
// previous result is still held in the output register. A batch close keeps
// the input stalled while it scans the sample store forward and backward (an
// entry read takes a read state and a check state, one store port), runs four
// serial divisions (each a start, the shift steps and a hand-off), updates and
// decodes. With no lit sample the backward scan and the divisions are skipped,
// and a batch of four samples or fewer goes straight to decode. A batch holds
// at most 32 entries. Configuration is always ready.
`default_nettype none

`include "optical_gesture_classifier_defines.svh"

module optical_gesture_classifier (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_stall,
    input  wire logic [1:0]         cmd,
    input  wire logic [7:0]         up_level,
    input  wire logic [7:0]         down_level,
    input  wire logic [7:0]         left_level,
    input  wire logic [7:0]         right_level,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [2:0]              gesture_code,
    output logic signed [15:0]      vertical_total,
    output logic signed [15:0]      horizontal_total,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [8:0]         cfg_data
);
    import ogc_pkg::*;

    ogc_cmd_t    ctl;
    ogc_status_t st;

    assign cfg_ready = 1'b1;

    // controller
    ogc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .cmd          (cmd),
        .result_busy  (result_valid),
        .st           (st),
        .sample_stall (sample_stall),
        .ctl          (ctl)
    );

    // datapath
    ogc_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .st               (st),
        .cmd              (cmd),
        .up_level         (up_level),
        .down_level       (down_level),
        .left_level       (left_level),
        .right_level      (right_level),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .gesture_code     (gesture_code),
        .vertical_total   (vertical_total),
        .horizontal_total (horizontal_total)
    );

    // a finish beat always lands in the result register
    `OGC_ASSERT_NEXT(a_finish_emits, ctl.accept && cmd == CMD_FINISH, result_valid)

    // a close beat keeps the input stalled in the following cycle
    `OGC_ASSERT_NEXT(a_close_blocks, ctl.accept && cmd == CMD_CLOSE, sample_stall)

    // the divider never runs while a new beat is taken
    `OGC_ASSERT_IMP(a_div_idle_on_accept, ctl.accept, !st.div_busy)

endmodule

`default_nettype wire
